// ===== rtl/lmsd_pkg.sv =====
// lmsd_pkg: shared types, constants and codes for the lightmap accumulator
// used by lmsd_lane, lmsd_falloff and the top level
package lmsd_pkg;

   localparam int MAX_SIDE    = 18;
   localparam int SIDE_W      = 5;
   localparam int TEXELS      = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W      = $clog2(TEXELS);
   localparam int CNT_W       = $clog2(TEXELS + 1);
   localparam int TABLE_DEPTH = 8192;
   localparam int TBL_W       = $clog2(TABLE_DEPTH);
   localparam int RECIP_W     = 14;
   localparam int DIV_STAGES  = RECIP_W;
   localparam int FALL_LAT    = DIV_STAGES + 2;
   localparam int DRAIN_W     = 5;
   localparam logic [DRAIN_W-1:0] LIGHT_DRAIN = DRAIN_W'(FALL_LAT + 1);
   localparam logic [RECIP_W-1:0] RECIP_ZERO  = RECIP_W'(1048576 >> 7);
   localparam logic [RECIP_W-1:0] RECIP_NUM   = RECIP_W'(1048576 >> 7);
   localparam logic [20:0] MAXD_LIMIT = 21'd1048576;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_STYLE = 2'd1,
      CMD_LIGHT = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      LOP_NONE,
      LOP_FILL,
      LOP_STYLE,
      LOP_LIGHT,
      LOP_READ
   } lane_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_LIGHT,
      ST_DRAIN,
      ST_WAIT
   } state_type;

   typedef struct packed {
      cmd_type            command;
      logic [4:0]         width;
      logic [4:0]         height;
      logic               no_light_data;
      logic [20:0]        factor;
      logic [21:0]        channel_a;
      logic [21:0]        channel_b;
      logic [21:0]        channel_c;
      logic signed [15:0] light_s;
      logic signed [15:0] light_t;
      logic [20:0]        dist_sq;
   } req_data_type;

   typedef struct packed {
      logic [7:0] out_r;
      logic [7:0] out_g;
      logic [7:0] out_b;
      logic [7:0] out_a;
      logic       last;
   } rsp_data_type;

   typedef struct packed {
      lane_op_type       op;
      logic [ADDR_W-1:0] addr;
      logic [21:0]       ch;
      logic [20:0]       mult;
      logic              ones;
   } lane_req_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] data;
   } lane_rsp_type;

   typedef struct packed {
      logic               valid;
      logic signed [16:0] ds;
      logic signed [16:0] dt;
      logic [20:0]        dsq;
      logic [20:0]        maxd;
      logic [ADDR_W-1:0]  addr;
   } fall_in_type;

   typedef struct packed {
      logic               valid;
      logic               lit;
      logic [RECIP_W-1:0] recip;
      logic [ADDR_W-1:0]  addr;
   } fall_out_type;

endpackage

// ===== rtl/lmsd_lane.sv =====
// lmsd_lane: one color lane, texel store with read-modify-write multiply-add
// depends on lmsd_pkg
module lmsd_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  lmsd_pkg::lane_req_type lane_req,
   output lmsd_pkg::lane_rsp_type lane_rsp
);
   import lmsd_pkg::*;

   logic [31:0]       mem [0:TEXELS-1];
   logic [31:0]       rdata_ff;
   logic [42:0]       prod_ff;
   lane_op_type       op_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic              ones_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= LOP_NONE;
      end else begin
         op_ff <= lane_req.op;
      end
      addr_ff  <= lane_req.addr;
      ones_ff  <= lane_req.ones;
      prod_ff  <= 43'(lane_req.ch) * 43'(lane_req.mult);
      rdata_ff <= mem[lane_req.addr];
   end

   always_ff @(posedge clock) begin
      case (op_ff)
         LOP_FILL:  mem[addr_ff] <= ones_ff ? 32'hFFFF_FFFF : 32'h0;
         LOP_STYLE: mem[addr_ff] <= rdata_ff + prod_ff[31:0];
         LOP_LIGHT: mem[addr_ff] <= rdata_ff + prod_ff[38:7];
         default: ;
      endcase
   end

   assign lane_rsp.valid = (op_ff == LOP_READ);
   assign lane_rsp.data  = rdata_ff;

endmodule

// ===== rtl/lmsd_falloff.sv =====
// lmsd_falloff: pipelined radial falloff, squares, range test and reciprocal
// by a one-bit-per-stage divider; depends on lmsd_pkg
module lmsd_falloff (
   input  logic                  clock,
   input  logic                  reset,
   input  lmsd_pkg::fall_in_type  fall_in,
   output lmsd_pkg::fall_out_type fall_out
);
   import lmsd_pkg::*;

   logic               v1_ff;
   logic [30:0]        sqs_ff;
   logic [30:0]        sqt_ff;
   logic [20:0]        dist_ff;
   logic [20:0]        maxd_ff;
   logic [ADDR_W-1:0]  addr1_ff;
   logic signed [33:0] sqs_full;
   logic signed [33:0] sqt_full;
   logic [31:0]        sum;

   logic               dv_ff   [0:DIV_STAGES];
   logic               dlit_ff [0:DIV_STAGES];
   logic [TBL_W-1:0]   dn_ff   [0:DIV_STAGES];
   logic [TBL_W-1:0]   dr_ff   [0:DIV_STAGES];
   logic [RECIP_W-1:0] dq_ff   [0:DIV_STAGES];
   logic [ADDR_W-1:0]  da_ff   [0:DIV_STAGES];
   logic [TBL_W:0]     rsh     [1:DIV_STAGES];
   logic               ge      [1:DIV_STAGES];

   assign sqs_full = fall_in.ds * fall_in.ds;
   assign sqt_full = fall_in.dt * fall_in.dt;
   assign sum = 32'(sqs_ff) + 32'(sqt_ff) + 32'(dist_ff);

   always_comb begin
      for (int i = 1; i <= DIV_STAGES; i++) begin
         rsh[i] = {dr_ff[i-1], RECIP_NUM[DIV_STAGES-i]};
         ge[i]  = (rsh[i] >= {1'b0, dn_ff[i-1]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         for (int i = 0; i <= DIV_STAGES; i++) begin
            dv_ff[i] <= 1'b0;
         end
      end else begin
         v1_ff    <= fall_in.valid;
         dv_ff[0] <= v1_ff;
         for (int i = 1; i <= DIV_STAGES; i++) begin
            dv_ff[i] <= dv_ff[i-1];
         end
      end
      sqs_ff     <= sqs_full[30:0];
      sqt_ff     <= sqt_full[30:0];
      dist_ff    <= fall_in.dsq;
      maxd_ff    <= fall_in.maxd;
      addr1_ff   <= fall_in.addr;
      dlit_ff[0] <= (sum < {11'b0, maxd_ff});
      dn_ff[0]   <= sum[TBL_W+6:7];
      dr_ff[0]   <= '0;
      dq_ff[0]   <= '0;
      da_ff[0]   <= addr1_ff;
      for (int i = 1; i <= DIV_STAGES; i++) begin
         dlit_ff[i] <= dlit_ff[i-1];
         dn_ff[i]   <= dn_ff[i-1];
         da_ff[i]   <= da_ff[i-1];
         dq_ff[i]   <= {dq_ff[i-1][RECIP_W-2:0], ge[i]};
         dr_ff[i]   <= ge[i] ? TBL_W'(rsh[i] - {1'b0, dn_ff[i-1]}) : rsh[i][TBL_W-1:0];
      end
   end

   assign fall_out.valid = dv_ff[DIV_STAGES];
   assign fall_out.lit   = dlit_ff[DIV_STAGES];
   assign fall_out.recip = (dn_ff[DIV_STAGES] == '0) ? RECIP_ZERO : dq_ff[DIV_STAGES];
   assign fall_out.addr  = da_ff[DIV_STAGES];

endmodule

// ===== rtl/lightmap_style_and_dlight_accumulator.sv =====
// lightmap_style_and_dlight_accumulator: top level, command sequencer, csr port,
// three lmsd_lane instances, lmsd_falloff and the output register; uses lmsd_pkg
//
// Items are taken one at a time. A style or read request passes through the wait
// state before the next request is taken. A start request fills the store,
// one texel written per cycle, then passes through the wait state. A light
// request walks the surface and issues one texel per cycle into the
// falloff pipeline (squares, range test, 14-stage reciprocal divider), then
// the pipeline drains into the stores. A read waits while an earlier texel
// still sits in the output register. The store holds no defined value until
// the first start request.
module lightmap_style_and_dlight_accumulator (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lmsd_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lmsd_pkg::rsp_data_type rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   import lmsd_pkg::*;

   state_type          state_ff, state_in;
   logic [3:0]         shift_ff;
   logic [1:0]         fmt_ff;
   logic [SIDE_W-1:0]  width_ff;
   logic [CNT_W-1:0]   count_ff;
   logic [ADDR_W-1:0]  wr_idx_ff, rd_idx_ff, idx_ff, col_ff;
   logic [DRAIN_W-1:0] drain_ff;
   logic               ones_ff, last_ff;
   logic signed [16:0] ls_ff, ds_ff, dt_ff;
   logic [20:0]        dist_ff, maxd_ff;
   logic [21:0]        ch_ff [0:2];
   logic               rsp_valid_ff;
   rsp_data_type       rsp_data_ff;
   logic               accept, mono, walk_end;
   logic [ADDR_W-1:0]  last_idx;
   logic [SIDE_W-1:0]  w_cl, h_cl;
   logic [21:0]        req_ch [0:2];
   lane_req_type       lane_req [0:2];
   lane_rsp_type       lane_rsp [0:2];
   fall_in_type        fall_in;
   fall_out_type       fall_out;
   logic               csr_wr;

   function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
      if (v == '0) begin
         return SIDE_W'(1);
      end else if (v > SIDE_W'(MAX_SIDE)) begin
         return SIDE_W'(MAX_SIDE);
      end
      return v;
   endfunction

   function automatic logic [7:0] to_byte(input logic [31:0] v, input logic [3:0] sh);
      logic [31:0] x;
      x = v >> sh;
      return (x > 32'd255) ? 8'd255 : x[7:0];
   endfunction

   assign mono     = (fmt_ff == 2'd0);
   assign accept   = req_valid && req_ready;
   assign last_idx = ADDR_W'(count_ff - 1'b1);
   assign walk_end = (idx_ff == last_idx);
   assign w_cl     = clamp_side(req_data.width);
   assign h_cl     = clamp_side(req_data.height);
   assign req_ch[0] = req_data.channel_a;
   assign req_ch[1] = req_data.channel_b;
   assign req_ch[2] = req_data.channel_c;

   // csr port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = csr_paddr[2] ? {30'b0, fmt_ff} : {28'b0, shift_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.command)
                  CMD_START: state_in = ST_FILL;
                  CMD_LIGHT: state_in = ST_LIGHT;
                  default:   state_in = ST_WAIT;
               endcase
            end
         end
         ST_FILL:  state_in = walk_end ? ST_WAIT : ST_FILL;
         ST_LIGHT: state_in = walk_end ? ST_DRAIN : ST_LIGHT;
         ST_DRAIN: state_in = (drain_ff == '0) ? ST_IDLE : ST_DRAIN;
         ST_WAIT:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE)
                  && !(rsp_valid_ff && (req_data.command == CMD_READ));
      fall_in.valid = (state_ff == ST_LIGHT);
      fall_in.ds    = ds_ff;
      fall_in.dt    = dt_ff;
      fall_in.dsq   = dist_ff;
      fall_in.maxd  = maxd_ff;
      fall_in.addr  = idx_ff;
      for (int k = 0; k < 3; k++) begin
         lane_req[k].op   = LOP_NONE;
         lane_req[k].addr = idx_ff;
         lane_req[k].ch   = ch_ff[k];
         lane_req[k].mult = {7'b0, fall_out.recip};
         lane_req[k].ones = ones_ff;
         if (state_ff == ST_FILL) begin
            lane_req[k].op = LOP_FILL;
         end else if (fall_out.valid && fall_out.lit) begin
            lane_req[k].op   = (k == 0 || !mono) ? LOP_LIGHT : LOP_NONE;
            lane_req[k].addr = fall_out.addr;
         end else if (accept && req_data.command == CMD_STYLE) begin
            lane_req[k].op   = (k == 0 || !mono) ? LOP_STYLE : LOP_NONE;
            lane_req[k].addr = wr_idx_ff;
            lane_req[k].ch   = req_ch[k];
            lane_req[k].mult = req_data.factor;
         end else if (accept && req_data.command == CMD_READ) begin
            lane_req[k].op   = LOP_READ;
            lane_req[k].addr = rd_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         shift_ff     <= 4'd7;
         fmt_ff       <= 2'd2;
         width_ff     <= SIDE_W'(1);
         count_ff     <= CNT_W'(1);
         wr_idx_ff    <= '0;
         rd_idx_ff    <= '0;
         idx_ff       <= '0;
         col_ff       <= '0;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr) begin
            if (csr_paddr[2]) begin
               fmt_ff <= csr_pwdata[1:0];
            end else begin
               shift_ff <= csr_pwdata[3:0];
            end
         end
         if (accept) begin
            idx_ff <= '0;
            col_ff <= '0;
            case (req_data.command)
               CMD_START: begin
                  width_ff  <= w_cl;
                  count_ff  <= CNT_W'(w_cl) * CNT_W'(h_cl);
                  wr_idx_ff <= '0;
                  rd_idx_ff <= '0;
               end
               CMD_STYLE: begin
                  wr_idx_ff <= (wr_idx_ff == last_idx) ? '0 : ADDR_W'(wr_idx_ff + 1'b1);
               end
               CMD_READ: begin
                  rd_idx_ff <= (rd_idx_ff == last_idx) ? '0 : ADDR_W'(rd_idx_ff + 1'b1);
               end
               default: ;
            endcase
         end else if (state_ff == ST_FILL || state_ff == ST_LIGHT) begin
            idx_ff <= ADDR_W'(idx_ff + 1'b1);
            if (col_ff == ADDR_W'(width_ff - 1'b1)) begin
               col_ff <= '0;
            end else begin
               col_ff <= ADDR_W'(col_ff + 1'b1);
            end
         end
         if (state_ff == ST_LIGHT) begin
            drain_ff <= LIGHT_DRAIN;
         end else if (drain_ff != '0) begin
            drain_ff <= DRAIN_W'(drain_ff - 1'b1);
         end
         if (lane_rsp[0].valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         ones_ff  <= req_data.no_light_data;
         ls_ff    <= 17'(req_data.light_s);
         ds_ff    <= 17'(req_data.light_s);
         dt_ff    <= 17'(req_data.light_t);
         dist_ff  <= req_data.dist_sq;
         maxd_ff  <= (req_data.factor > MAXD_LIMIT) ? MAXD_LIMIT : req_data.factor;
         last_ff  <= (rd_idx_ff == last_idx);
         for (int k = 0; k < 3; k++) begin
            ch_ff[k] <= req_ch[k];
         end
      end else if (state_ff == ST_LIGHT) begin
         if (col_ff == ADDR_W'(width_ff - 1'b1)) begin
            ds_ff <= ls_ff;
            dt_ff <= dt_ff - 17'sd16;
         end else begin
            ds_ff <= ds_ff - 17'sd16;
         end
      end
      if (lane_rsp[0].valid) begin
         rsp_data_ff.out_r <= to_byte(lane_rsp[0].data, shift_ff);
         rsp_data_ff.out_g <= mono ? 8'd0 : to_byte(lane_rsp[1].data, shift_ff);
         rsp_data_ff.out_b <= mono ? 8'd0 : to_byte(lane_rsp[2].data, shift_ff);
         rsp_data_ff.out_a <= (fmt_ff >= 2'd2) ? 8'd255 : 8'd0;
         rsp_data_ff.last  <= last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   lmsd_falloff u_falloff (
      .clock    (clock),
      .reset    (reset),
      .fall_in  (fall_in),
      .fall_out (fall_out)
   );

   for (genvar k = 0; k < 3; k++) begin : g_lane
      lmsd_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .lane_req (lane_req[k]),
         .lane_rsp (lane_rsp[k])
      );
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == ST_IDLE))
      else $error("request taken while busy");

   a_read_slot: assert property (@(posedge clock) disable iff (reset)
      lane_rsp[0].valid |-> !rsp_valid_ff)
      else $error("texel read landed on a full output register");

   a_walk_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LIGHT || state_ff == ST_FILL) |-> (CNT_W'(idx_ff) < count_ff))
      else $error("walk past surface end");

   a_fall_busy: assert property (@(posedge clock) disable iff (reset)
      fall_out.valid |-> (state_ff == ST_LIGHT || state_ff == ST_DRAIN))
      else $error("falloff result outside light pass");

endmodule

// ===== tb/sv/tb_lightmap_style_and_dlight_accumulator.sv =====
// tb_lightmap_style_and_dlight_accumulator: self-checking bench for the lightmap accumulator
// directed table then random surface sequences, checked against an in-bench texel store model
// depends on lmsd_pkg and lightmap_style_and_dlight_accumulator
module tb_lightmap_style_and_dlight_accumulator;
   timeunit 1ns;
   timeprecision 1ps;
   import lmsd_pkg::*;

   localparam logic [2:0] ADDR_SHIFT  = 3'd0;
   localparam logic [2:0] ADDR_FORMAT = 3'd4;
   localparam logic [1:0] FMT_MONO = 2'd0;
   localparam logic [1:0] FMT_RGB  = 2'd1;
   localparam logic [1:0] FMT_RGBA = 2'd2;
   localparam logic [1:0] FMT_ALT  = 2'd3;
   localparam int SETTLE_CYCLES = 400;
   localparam int STALL_LIMIT   = 5000;
   localparam int N_DIRECTED    = 24;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_data_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_data_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   lightmap_style_and_dlight_accumulator DUT (.*);

   // texel store model
   logic [31:0] texel_acc [TEXELS][3];
   int unsigned recip [TABLE_DEPTH];
   int unsigned surf_w = 1, surf_h = 1, wr_idx = 0, rd_idx = 0;
   logic [3:0] shift_cfg = 4'd7;
   logic [1:0] format_cfg = FMT_RGBA;

   rsp_data_type texels_due [$];
   rsp_data_type typed_due [$];
   bit use_typed = 1'b0;
   int errors = 0, n_sent = 0, n_texels = 0, n_lights = 0, n_styles = 0, n_starts = 0;
   int idle_cnt = 0;
   int snd_idle = 0, rcv_idle = 0;

   typedef struct {
      req_data_type d;
      bit           typed;
      rsp_data_type e;
   } row_type;
   row_type dir_tab [N_DIRECTED];

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned clamp_side(logic [4:0] v);
      if (v == 0) return 1;
      if (v > MAX_SIDE) return MAX_SIDE;
      return v;
   endfunction

   function automatic logic [7:0] to_byte(logic [31:0] v);
      logic [31:0] x;
      x = v >> shift_cfg;
      return (x > 255) ? 8'd255 : x[7:0];
   endfunction

   function automatic void light_texels(req_data_type d, bit mono);
      longint unsigned maxd, sum, j;
      longint ds, dt;
      logic [21:0] ch [3];
      int unsigned base;
      ch[0] = d.channel_a;
      ch[1] = d.channel_b;
      ch[2] = d.channel_c;
      maxd = (d.factor > MAXD_LIMIT) ? MAXD_LIMIT : d.factor;
      for (int r = 0; r < surf_h; r++) begin
         dt = longint'(d.light_t) - 16 * r;
         for (int c = 0; c < surf_w; c++) begin
            ds = longint'(d.light_s) - 16 * c;
            sum = ds * ds + dt * dt + d.dist_sq;
            base = r * surf_w + c;
            if (sum < maxd) begin
               j = recip[(sum >> 7) % TABLE_DEPTH];
               for (int k = 0; k < (mono ? 1 : 3); k++)
                  texel_acc[base][k] += 32'((longint'(ch[k]) * j) >> 7);
            end
         end
      end
   endfunction

   function automatic void predict(req_data_type d);
      bit mono;
      int unsigned cnt, idx;
      logic [21:0] ch [3];
      rsp_data_type e;
      mono = (format_cfg == FMT_MONO);
      ch[0] = d.channel_a;
      ch[1] = d.channel_b;
      ch[2] = d.channel_c;
      cnt = surf_w * surf_h;
      case (d.command)
         CMD_START: begin
            surf_w = clamp_side(d.width);
            surf_h = clamp_side(d.height);
            foreach (texel_acc[i, k]) texel_acc[i][k] = {32{d.no_light_data}};
            wr_idx = 0;
            rd_idx = 0;
            n_starts++;
         end
         CMD_STYLE: begin
            for (int k = 0; k < (mono ? 1 : 3); k++)
               texel_acc[wr_idx % cnt][k] += 32'(longint'(ch[k]) * d.factor);
            wr_idx = (wr_idx + 1 >= cnt) ? 0 : wr_idx + 1;
            n_styles++;
         end
         CMD_LIGHT: begin
            light_texels(d, mono);
            n_lights++;
         end
         default: begin
            idx = rd_idx % cnt;
            e.out_r = to_byte(texel_acc[idx][0]);
            e.out_g = mono ? 8'd0 : to_byte(texel_acc[idx][1]);
            e.out_b = mono ? 8'd0 : to_byte(texel_acc[idx][2]);
            e.out_a = (format_cfg >= FMT_RGBA) ? 8'd255 : 8'd0;
            e.last = (idx + 1 == cnt);
            rd_idx = (idx + 1 >= cnt) ? 0 : idx + 1;
            if (use_typed && typed_due.size() > 0) e = typed_due.pop_front();
            texels_due.push_back(e);
         end
      endcase
   endfunction

   task automatic check_texel(rsp_data_type got);
      rsp_data_type e;
      if (texels_due.size() == 0) begin
         $display("%0t unexpected texel %p", $time, got);
         errors++;
         return;
      end
      e = texels_due.pop_front();
      n_texels++;
      if (got.out_r !== e.out_r) $display("%0t out_r exp %0d got %0d", $time, e.out_r, got.out_r);
      if (got.out_g !== e.out_g) $display("%0t out_g exp %0d got %0d", $time, e.out_g, got.out_g);
      if (got.out_b !== e.out_b) $display("%0t out_b exp %0d got %0d", $time, e.out_b, got.out_b);
      if (got.out_a !== e.out_a) $display("%0t out_a exp %0d got %0d", $time, e.out_a, got.out_a);
      if (got.last !== e.last) $display("%0t last exp %0d got %0d", $time, e.last, got.last);
      if (got !== e) errors++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) check_texel(rsp_data);
         if (req_valid && req_ready) predict(req_data);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready) ||
             (csr_psel && csr_penable)) idle_cnt <= 0;
         else idle_cnt <= idle_cnt + 1;
         if (idle_cnt >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= rcv_idle);
   end

   function automatic req_data_type mk(cmd_type cmd, logic [4:0] w, logic [4:0] h, logic nld,
                                        logic [20:0] f, logic [21:0] a, logic [21:0] b,
                                        logic [21:0] c, logic [15:0] s, logic [15:0] t,
                                        logic [20:0] dd);
      req_data_type d;
      d.command = cmd;
      d.width = w;
      d.height = h;
      d.no_light_data = nld;
      d.factor = f;
      d.channel_a = a;
      d.channel_b = b;
      d.channel_c = c;
      d.light_s = s;
      d.light_t = t;
      d.dist_sq = dd;
      return d;
   endfunction

   task automatic send(req_data_type d);
      if ($urandom_range(99) < snd_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < snd_idle) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= d;
      n_sent++;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (texels_due.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == ADDR_SHIFT) shift_cfg = val[3:0];
      else format_cfg = val[1:0];
   endtask

   function automatic req_data_type rand_field_item(cmd_type cmd);
      return mk(cmd, 5'($urandom), 5'($urandom), 1'($urandom),
                21'($urandom_range(0, 1048576)), 22'($urandom), 22'($urandom),
                22'($urandom), 16'($urandom), 16'($urandom), 21'($urandom));
   endfunction

   task automatic surface_seq();
      int r, w, h, cnt, passes, lights, reads;
      req_data_type d;
      r = $urandom_range(99);
      w = (r < 85) ? $urandom_range(1, 4) : (r < 95) ? $urandom_range(5, 8) :
          (r < 98) ? $urandom_range(0, 31) : MAX_SIDE;
      h = (r < 85) ? $urandom_range(1, 4) : (r < 95) ? $urandom_range(1, 4) :
          (r < 98) ? $urandom_range(0, 31) : MAX_SIDE;
      send(mk(CMD_START, 5'(w), 5'(h), 1'($urandom_range(0, 5) == 0), 21'($urandom),
              22'($urandom), 22'($urandom), 22'($urandom), 16'($urandom), 16'($urandom),
              21'($urandom)));
      cnt = clamp_side(5'(w)) * clamp_side(5'(h));
      passes = (cnt > 36) ? 0 : $urandom_range(0, 2);
      for (int p = 0; p < passes * cnt; p++) begin
         d = rand_field_item(CMD_STYLE);
         if ($urandom_range(3) != 0) begin
            d.channel_a = $urandom_range(0, 255);
            d.channel_b = $urandom_range(0, 255);
            d.channel_c = $urandom_range(0, 255);
            d.factor = $urandom_range(0, 1024);
         end
         send(d);
      end
      lights = $urandom_range(0, 2);
      for (int l = 0; l < lights; l++) begin
         d = rand_field_item(CMD_LIGHT);
         if ($urandom_range(4) != 0) begin
            d.light_s = $urandom_range(0, 16 * cnt + 128) - 64;
            d.light_t = $urandom_range(0, 160) - 64;
            d.dist_sq = $urandom_range(0, 60000);
            d.factor = $urandom_range(20000, 1048576);
            if ($urandom_range(1)) begin
               d.channel_a = $urandom_range(0, 65535);
               d.channel_b = $urandom_range(0, 65535);
               d.channel_c = $urandom_range(0, 65535);
            end
         end
         send(d);
      end
      reads = (cnt > 64) ? $urandom_range(1, 40) : cnt + $urandom_range(0, 2);
      for (int i = 0; i < reads; i++) begin
         if ($urandom_range(9) == 0) send(rand_field_item(cmd_type'($urandom_range(1, 3))));
         send(rand_field_item(CMD_READ));
      end
   endtask

   task automatic random_phase(int s_pct, int r_pct, int n);
      int stop_at;
      snd_idle = s_pct;
      rcv_idle = r_pct;
      stop_at = n_sent + n;
      while (n_sent < stop_at) surface_seq();
      drain();
   endtask

   initial begin
      rsp_data_type blank, bright;
      recip[0] = 1048576 >> 7;
      for (int n = 1; n < TABLE_DEPTH; n++) recip[n] = 1048576 / (n * 128);
      blank = '{out_r: 8'd0, out_g: 8'd0, out_b: 8'd0, out_a: 8'd255, last: 1'b1};
      bright = '{out_r: 8'd255, out_g: 8'd255, out_b: 8'd255, out_a: 8'd255, last: 1'b1};
      dir_tab[0]  = '{mk(CMD_START, 5'd1, 5'd1, 1'b0, '0, '0, '0, '0, '0, '0, '0), 0, '0};
      dir_tab[1]  = '{mk(CMD_READ, '0, '0, 1'b0, '0, '0, '0, '0, '0, '0, '0), 1, blank};
      dir_tab[2]  = '{mk(CMD_START, 5'd0, 5'd0, 1'b1, '0, '0, '0, '0, '0, '0, '0), 0, '0};
      dir_tab[3]  = '{mk(CMD_READ, '1, '1, 1'b1, '1, '1, '1, '1, '1, '1, '1), 1, bright};
      dir_tab[4]  = '{mk(CMD_STYLE, '0, '0, 1'b0, 21'd1048576, '1, '1, '1, '0, '0, '0), 0, '0};
      dir_tab[5]  = '{mk(CMD_READ, '0, '0, 1'b0, '0, '0, '0, '0, '0, '0, '0), 0, '0};
      dir_tab[6]  = '{mk(CMD_START, 5'd31, 5'd2, 1'b0, '0, '0, '0, '0, '0, '0, '0), 0, '0};
      dir_tab[7]  = '{mk(CMD_LIGHT, '0, '0, 1'b0, 21'd1048576, '1, '1, '1, '0, '0, '0), 0, '0};
      dir_tab[8]  = '{mk(CMD_LIGHT, '0, '0, 1'b0, 21'd1048576, '1, '1, '1,
                       16'h8000, 16'h7fff, 21'h1fffff), 0, '0};
      dir_tab[9]  = '{mk(CMD_LIGHT, '0, '0, 1'b0, 21'd1048576, 22'd5000, 22'd9000, 22'd77,
                       16'sd40, 16'sd8, 21'd100), 0, '0};
      dir_tab[10] = '{mk(CMD_STYLE, '0, '0, 1'b0, 21'd0, '1, '1, '1, '0, '0, '0), 0, '0};
      dir_tab[11] = '{mk(CMD_STYLE, '0, '0, 1'b0, 21'd256, 22'd255, 22'd128, 22'd1,
                       '0, '0, '0), 0, '0};
      dir_tab[12] = '{mk(CMD_READ, '0, '0, 1'b0, '0, '0, '0, '0, '0, '0, '0), 0, '0};
      dir_tab[13] = '{mk(CMD_READ, '0, '0, 1'b0, '0, '0, '0, '0, '0, '0, '0), 0, '0};
      dir_tab[14] = '{mk(CMD_READ, '0, '0, 1'b0, '0, '0, '0, '0, '0, '0, '0), 0, '0};
      dir_tab[15] = '{mk(CMD_START, 5'd2, 5'd1, 1'b0, '0, '0, '0, '0, '0, '0, '0), 0, '0};
      dir_tab[16] = '{mk(CMD_STYLE, '0, '0, 1'b0, 21'd256, 22'd200, 22'd100, 22'd50,
                       '0, '0, '0), 0, '0};
      dir_tab[17] = '{mk(CMD_STYLE, '0, '0, 1'b0, 21'd512, 22'd10, 22'd20, 22'd30,
                       '0, '0, '0), 0, '0};
      dir_tab[18] = '{mk(CMD_STYLE, '0, '0, 1'b0, 21'd128, 22'd255, 22'd255, 22'd255,
                       '0, '0, '0), 0, '0};
      dir_tab[19] = '{mk(CMD_LIGHT, '0, '0, 1'b0, 21'd2000, 22'd1000, 22'd1000, 22'd1000,
                       16'sd16, '0, '0), 0, '0};
      dir_tab[20] = '{mk(CMD_READ, '0, '0, 1'b0, '0, '0, '0, '0, '0, '0, '0), 0, '0};
      dir_tab[21] = '{mk(CMD_READ, '0, '0, 1'b0, '0, '0, '0, '0, '0, '0, '0), 0, '0};
      dir_tab[22] = '{mk(CMD_READ, '0, '0, 1'b0, '0, '0, '0, '0, '0, '0, '0), 0, '0};
      dir_tab[23] = '{mk(CMD_START, 5'd3, 5'd3, 1'b1, '0, '0, '0, '0, '0, '0, '0), 0, '0};

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      use_typed = 1'b1;
      foreach (dir_tab[i]) begin
         if (dir_tab[i].typed) typed_due.push_back(dir_tab[i].e);
         send(dir_tab[i].d);
         wait (typed_due.size() == 0 || !dir_tab[i].typed);
      end
      drain();
      use_typed = 1'b0;

      csr_write(ADDR_SHIFT, 32'd9);
      csr_write(ADDR_FORMAT, FMT_MONO);
      random_phase(8, 86, 370);
      csr_write(ADDR_SHIFT, 32'd8);
      csr_write(ADDR_FORMAT, FMT_RGB);
      random_phase(86, 8, 370);
      csr_write(ADDR_SHIFT, 32'd7);
      csr_write(ADDR_FORMAT, FMT_ALT);
      random_phase(0, 0, 180);
      csr_write(ADDR_FORMAT, FMT_RGBA);
      random_phase(0, 0, 180);

      $display("sent %0d requests: %0d starts, %0d style texels, %0d lights",
               n_sent, n_starts, n_styles, n_lights);
      $display("checked %0d texels over shifts 7..9 and all pixel formats", n_texels);
      if (errors == 0 && texels_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/lmsd_pkg.sv
rtl/lmsd_lane.sv
rtl/lmsd_falloff.sv
rtl/lightmap_style_and_dlight_accumulator.sv
tb/sv/tb_lightmap_style_and_dlight_accumulator.sv
